// ===== rtl/redundant_block_merge_voter_defines.svh =====
// assertion helpers used by the checker file
`ifndef REDUNDANT_BLOCK_MERGE_VOTER_DEFINES_SVH
`define REDUNDANT_BLOCK_MERGE_VOTER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define RBMV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define RBMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rbmv_pkg.sv =====
package rbmv_pkg;

	localparam int MAX_IMAGES = 4;
	localparam int LANES      = 4;
	localparam int PAIRS      = 6;

	localparam int IMG_COUNT_MIN = 2;
	localparam int IMG_COUNT_MAX = (MAX_IMAGES < LANES) ? MAX_IMAGES : LANES;

	localparam logic [7:0] STATUS_GOOD     = 8'd1;
	localparam logic [7:0] STATUS_NOT_READ = 8'd0;

	localparam logic [2:0] IMG_COUNT_RESET  = 3'd2;
	localparam logic [7:0] WEAK_ENTRY_RESET = 8'd1;

	typedef enum logic [1:0] {
		CFG_IMAGE_COUNT = 2'd0,
		CFG_WEAK_ENTRY  = 2'd1
	} cfg_index_t;

	typedef logic [1:0] img_idx_t;
	typedef logic [1:0] score_t;
	typedef logic [LANES-1:0][7:0] lane_bytes_t;

	// pair order (0,1),(0,2),(0,3),(1,2),(1,3),(2,3)
	localparam img_idx_t PAIR_LO [PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam img_idx_t PAIR_HI [PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

	typedef struct packed {
		logic [2:0] image_count;
		logic [7:0] weak_entry;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [PAIRS-1:0] diff;
		lane_bytes_t      status;
	} stage_t;

	typedef struct packed {
		img_idx_t   chosen_image;
		logic [7:0] merged_status;
		logic       reads_differ;
		logic       still_bad;
		score_t     best_score;
	} result_t;

	function automatic logic status_bad(input logic [7:0] s);
		return (s != STATUS_NOT_READ) && (s != STATUS_GOOD);
	endfunction

endpackage

// ===== rtl/rbmv_cfg_regs.sv =====
module rbmv_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output rbmv_pkg::cfg_t cfg
);

	logic [2:0] image_count_q;
	logic [7:0] weak_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_count_q <= rbmv_pkg::IMG_COUNT_RESET;
			weak_entry_q  <= rbmv_pkg::WEAK_ENTRY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rbmv_pkg::CFG_IMAGE_COUNT: image_count_q <= cfg_data[2:0];
				rbmv_pkg::CFG_WEAK_ENTRY:  weak_entry_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.image_count = image_count_q;
	assign cfg.weak_entry  = weak_entry_q;

endmodule

// ===== rtl/rbmv_pair_cmp.sv =====
module rbmv_pair_cmp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  rbmv_pkg::lane_bytes_t bytes_in,
	input  rbmv_pkg::lane_bytes_t status_in,
	input  logic                  last_in,
	output rbmv_pkg::stage_t      stage_s2
);

	logic                  valid_s1;
	logic                  last_s1;
	rbmv_pkg::lane_bytes_t bytes_s1;
	rbmv_pkg::lane_bytes_t status_s1;
	logic [rbmv_pkg::PAIRS-1:0] diff;
	logic                  valid_s2;
	logic                  last_s2;
	logic [rbmv_pkg::PAIRS-1:0] diff_s2;
	rbmv_pkg::lane_bytes_t status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			bytes_s1  <= bytes_in;
			status_s1 <= status_in;
			last_s1   <= last_in;
		end
	end

	always_comb begin
		for (int p = 0; p < rbmv_pkg::PAIRS; p++) begin
			diff[p] = bytes_s1[rbmv_pkg::PAIR_LO[p]] != bytes_s1[rbmv_pkg::PAIR_HI[p]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			last_s2   <= last_s1;
			diff_s2   <= diff;
			status_s2 <= status_s1;
		end
	end

	assign stage_s2 = {valid_s2, last_s2, diff_s2, status_s2};

endmodule

// ===== rtl/rbmv_decide.sv =====
module rbmv_decide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  rbmv_pkg::cfg_t     cfg,
	input  rbmv_pkg::stage_t   stage_s2,
	output logic               res_valid_q,
	output rbmv_pkg::result_t  res_q
);

	logic [rbmv_pkg::PAIRS-1:0] pair_mismatch_q;
	logic [rbmv_pkg::PAIRS-1:0] acc;
	logic [2:0]                 n_act;
	logic [rbmv_pkg::LANES-1:0] act;
	logic [rbmv_pkg::LANES-1:0] good;
	rbmv_pkg::score_t           score [rbmv_pkg::LANES];
	rbmv_pkg::score_t           hi;
	logic                       weak_hit;
	logic                       found_good;
	logic                       found_zero;
	rbmv_pkg::img_idx_t         pick_weak;
	rbmv_pkg::img_idx_t         pick_good;
	rbmv_pkg::img_idx_t         pick_zero;
	rbmv_pkg::result_t          res;

	assign acc = pair_mismatch_q | stage_s2.diff;

	// clamp the image count into the supported range
	always_comb begin
		n_act = cfg.image_count;
		if (n_act > 3'(rbmv_pkg::IMG_COUNT_MAX)) n_act = 3'(rbmv_pkg::IMG_COUNT_MAX);
		if (n_act < 3'(rbmv_pkg::IMG_COUNT_MIN)) n_act = 3'(rbmv_pkg::IMG_COUNT_MIN);
		for (int a = 0; a < rbmv_pkg::LANES; a++) begin
			act[a]  = 3'(a) < n_act;
			good[a] = act[a] && (stage_s2.status[a] == rbmv_pkg::STATUS_GOOD);
		end
	end

	always_comb begin
		weak_hit = 1'b0;
		for (int a = 0; a < rbmv_pkg::LANES; a++) score[a] = '0;
		for (int p = 0; p < rbmv_pkg::PAIRS; p++) begin
			if (good[rbmv_pkg::PAIR_LO[p]] && good[rbmv_pkg::PAIR_HI[p]]) begin
				if (acc[p]) begin
					weak_hit = 1'b1;
				end else begin
					score[rbmv_pkg::PAIR_LO[p]] = score[rbmv_pkg::PAIR_LO[p]] + 2'd1;
					score[rbmv_pkg::PAIR_HI[p]] = score[rbmv_pkg::PAIR_HI[p]] + 2'd1;
				end
			end
		end
	end

	// downward scans so the lowest matching image wins
	always_comb begin
		hi = '0;
		for (int a = 0; a < rbmv_pkg::LANES; a++) begin
			if (act[a] && score[a] > hi) hi = score[a];
		end
		pick_weak  = '0;
		pick_good  = '0;
		pick_zero  = '0;
		found_good = 1'b0;
		found_zero = 1'b0;
		for (int a = rbmv_pkg::LANES - 1; a >= 0; a--) begin
			if (act[a] && score[a] == hi) pick_weak = 2'(a);
			if (good[a]) begin
				pick_good  = 2'(a);
				found_good = 1'b1;
			end
			if (act[a] && stage_s2.status[a] == rbmv_pkg::STATUS_NOT_READ) begin
				pick_zero  = 2'(a);
				found_zero = 1'b1;
			end
		end
	end

	always_comb begin
		res.reads_differ = weak_hit;
		res.best_score   = weak_hit ? hi : '0;
		if (weak_hit) begin
			res.chosen_image  = pick_weak;
			res.merged_status = cfg.weak_entry;
		end else if (found_good) begin
			res.chosen_image  = pick_good;
			res.merged_status = rbmv_pkg::STATUS_GOOD;
		end else if (found_zero) begin
			res.chosen_image  = pick_zero;
			res.merged_status = rbmv_pkg::STATUS_NOT_READ;
		end else begin
			res.chosen_image  = '0;
			res.merged_status = stage_s2.status[0];
		end
		res.still_bad = rbmv_pkg::status_bad(res.merged_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mismatch_q <= '0;
			res_valid_q     <= 1'b0;
		end else if (adv) begin
			res_valid_q <= stage_s2.valid && stage_s2.last;
			if (stage_s2.valid) begin
				pair_mismatch_q <= stage_s2.last ? '0 : acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stage_s2.valid && stage_s2.last) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/redundant_block_merge_voter.sv =====
// a result appears once the beat carrying last_byte has passed stage s1, stage s2 and the result register
// throughput: one beat per cycle; the two pipe stages and the result register only pause
// while a result is held under out_stall, which also raises in_stall
// reset: arst_n clears the pipe valids, the pair mismatch flags and the result valid,
// image_count returns to 2 and weak_entry to 1
module redundant_block_merge_voter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_img0,
	input  logic [7:0] byte_img1,
	input  logic [7:0] byte_img2,
	input  logic [7:0] byte_img3,
	input  logic [7:0] status_img0,
	input  logic [7:0] status_img1,
	input  logic [7:0] status_img2,
	input  logic [7:0] status_img3,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] chosen_image,
	output logic [7:0] merged_status,
	output logic       reads_differ,
	output logic       still_bad,
	output logic [1:0] best_score,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	rbmv_pkg::cfg_t        cfg;
	rbmv_pkg::stage_t      stage_s2;
	rbmv_pkg::result_t     res_q;
	rbmv_pkg::lane_bytes_t bytes_in;
	rbmv_pkg::lane_bytes_t status_in;
	logic                  res_valid_q;
	logic                  adv;

	assign bytes_in  = {byte_img3, byte_img2, byte_img1, byte_img0};
	assign status_in = {status_img3, status_img2, status_img1, status_img0};

	// the whole pipe moves unless a result is held
	assign adv      = !(res_valid_q && out_stall);
	assign in_stall = !adv;

	rbmv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbmv_pair_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.bytes_in  (bytes_in),
		.status_in (status_in),
		.last_in   (last_byte),
		.stage_s2  (stage_s2)
	);

	rbmv_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg),
		.stage_s2    (stage_s2),
		.res_valid_q (res_valid_q),
		.res_q       (res_q)
	);

	assign out_valid     = res_valid_q;
	assign chosen_image  = res_q.chosen_image;
	assign merged_status = res_q.merged_status;
	assign reads_differ  = res_q.reads_differ;
	assign still_bad     = res_q.still_bad;
	assign best_score    = res_q.best_score;

endmodule

// ===== rtl/rbmv_checker.sv =====
`include "redundant_block_merge_voter_defines.svh"

module rbmv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] chosen_image,
	input logic [7:0] merged_status,
	input logic       reads_differ,
	input logic       still_bad,
	input logic [1:0] best_score
);

	`RBMV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`RBMV_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(chosen_image) && $stable(merged_status) && $stable(best_score), "stalled result changed")
	`RBMV_ASSERT_NOW(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with no held result")
	`RBMV_ASSERT_NOW(a_bad_flag, clk, arst_n, out_valid, still_bad == (merged_status != rbmv_pkg::STATUS_NOT_READ && merged_status != rbmv_pkg::STATUS_GOOD), "still_bad disagrees with merged status")
	`RBMV_ASSERT_NOW(a_score_weak, clk, arst_n, out_valid && !reads_differ, best_score == 2'd0, "score given for a block that is not weak")

endmodule

bind redundant_block_merge_voter rbmv_checker u_checker (.*);
